// ----- rtl/fcull_pkg.sv -----
// ----------------------------------------------------------------------------
// fcull_pkg: shared types and constants for the frustum cull test
// plane packing, query mode codes and exact fixed-point product helpers
// ----------------------------------------------------------------------------
package fcull_pkg;

    localparam int PLANE_COUNT = 6;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 64;
    localparam int COORD_W     = 22;
    localparam int NORM_W      = 14;
    localparam int FRAC_SHIFT  = 12;
    // one normal term: 14b x 22b signed, plus headroom for |n|
    localparam int PROD_W      = NORM_W + COORD_W + 1;
    // three terms plus the scaled plane distance
    localparam int SUM_W       = PROD_W + 2;
    // distance plus radius
    localparam int TEST_W      = SUM_W + 1;

    typedef enum logic [1:0] {
        MODE_POINT      = 2'd0,
        MODE_SPHERE     = 2'd1,
        MODE_BOX_MINMAX = 2'd2,
        MODE_BOX_EXT    = 2'd3
    } mode_t;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [NORM_W-1:0]  norm_t;
    typedef logic signed [PROD_W-1:0]  prod_t;
    typedef logic signed [SUM_W-1:0]   sum_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t z;
    } vec_t;

    // register layout, msb first: distance, nz, ny, nx
    typedef struct packed {
        coord_t offset;
        norm_t  nz;
        norm_t  ny;
        norm_t  nx;
    } plane_t;

    // exact signed product of a normal component and a coordinate
    function automatic prod_t mul_nc(norm_t n, coord_t c);
        prod_t nw;
        prod_t cw;
        nw = prod_t'(n);
        cw = prod_t'(c);
        return nw * cw;
    endfunction

    // exact product of a coordinate and the magnitude of a normal component
    function automatic prod_t mul_abs_nc(norm_t n, coord_t c);
        prod_t nw;
        prod_t cw;
        nw = prod_t'(n);
        cw = prod_t'(c);
        if (nw < 0)
        begin
            nw = -nw;
        end
        return nw * cw;
    endfunction

endpackage

// ----- rtl/frustum_cull_test.sv -----
// ----------------------------------------------------------------------------
// frustum_cull_test: six-plane view frustum visibility test
// point, sphere, min/max box and center/extent box queries, one per clock
// ----------------------------------------------------------------------------
// A query beat is taken at every rising edge where start is high and busy is
// low; busy never rises, so a new query can enter on every clock. Each query
// gives exactly one result beat: done rises with visible from the last of the
// four register stages (capture, multiply, sum, compare), and results leave in
// query order. The receiver cannot hold results off, so none is ever queued.
// The per-plane multipliers (14b x 22b) set the depth of the widest stage.
// Planes are written through wr_en / wr_index / wr_data (left, right, bottom,
// top, near, far at indexes 0 to 5; other indexes are ignored) and must only
// change while no query is in flight. All planes reset to zero, which makes
// every query visible but a sphere with a negative radius. Arithmetic is
// exact: a plane reports behind when n.p - d, widened by the sphere radius or
// the projected box radius, is below zero.
// ----------------------------------------------------------------------------
module frustum_cull_test (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration write port
    input  logic                                wr_en,
    input  logic [fcull_pkg::CFG_IDX_W-1:0]     wr_index,
    input  logic [fcull_pkg::CFG_DATA_W-1:0]    wr_data,
    // query command
    input  logic                                start,
    output logic                                busy,
    input  logic [1:0]                          mode,
    input  logic signed [fcull_pkg::COORD_W-1:0] first_x,
    input  logic signed [fcull_pkg::COORD_W-1:0] first_y,
    input  logic signed [fcull_pkg::COORD_W-1:0] first_z,
    input  logic signed [fcull_pkg::COORD_W-1:0] second_x,
    input  logic signed [fcull_pkg::COORD_W-1:0] second_y,
    input  logic signed [fcull_pkg::COORD_W-1:0] second_z,
    // result
    output logic                                done,
    output logic                                visible
);

    localparam int NP = fcull_pkg::PLANE_COUNT;

    // plane registers
    fcull_pkg::plane_t plane_reg [NP];

    // stage 0: captured query
    logic              s0_vld_reg;
    fcull_pkg::mode_t  s0_mode_reg;
    fcull_pkg::vec_t   s0_a_reg;
    fcull_pkg::vec_t   s0_b_reg;

    // stage 1: per-plane products
    logic              s1_vld_reg;
    fcull_pkg::mode_t  s1_mode_reg;
    fcull_pkg::coord_t s1_rad_reg;
    fcull_pkg::prod_t  s1_np_reg   [NP][3];
    fcull_pkg::prod_t  s1_np_next  [NP][3];
    fcull_pkg::prod_t  s1_rp_reg   [NP][3];
    fcull_pkg::prod_t  s1_rp_next  [NP][3];

    // stage 2: per-plane distance and radius
    logic              s2_vld_reg;
    fcull_pkg::sum_t   s2_dist_reg [NP];
    fcull_pkg::sum_t   s2_dist_next[NP];
    fcull_pkg::sum_t   s2_rad_reg  [NP];
    fcull_pkg::sum_t   s2_rad_next [NP];

    // stage 3: result
    logic              done_reg;
    logic              visible_reg;
    logic              visible_next;

    logic              accept;

    // never stalls: one query per clock
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // plane register writes, out-of-range indexes dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NP; i++)
            begin
                plane_reg[i] <= '0;
            end
        end
        else if (wr_en)
        begin
            for (int i = 0; i < NP; i++)
            begin
                if (wr_index == fcull_pkg::CFG_IDX_W'(i))
                begin
                    plane_reg[i] <= fcull_pkg::plane_t'(wr_data);
                end
            end
        end
    end

    // valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_vld_reg <= 1'b0;
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            s0_vld_reg <= accept;
            s1_vld_reg <= s0_vld_reg;
            s2_vld_reg <= s1_vld_reg;
            done_reg   <= s2_vld_reg;
        end
    end

    // stage 0: capture the query beat
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s0_mode_reg <= fcull_pkg::mode_t'(mode);
            s0_a_reg    <= '{x: first_x, y: first_y, z: first_z};
            s0_b_reg    <= '{x: second_x, y: second_y, z: second_z};
        end
    end

    // stage 1: vertex select and products, six planes in parallel
    always_comb
    begin
        fcull_pkg::coord_t px;
        fcull_pkg::coord_t py;
        fcull_pkg::coord_t pz;
        logic              box;
        box = (s0_mode_reg == fcull_pkg::MODE_BOX_MINMAX);
        for (int i = 0; i < NP; i++)
        begin
            // positive vertex: max corner where the normal is non-negative
            px = (box && !plane_reg[i].nx[fcull_pkg::NORM_W-1]) ? s0_b_reg.x : s0_a_reg.x;
            py = (box && !plane_reg[i].ny[fcull_pkg::NORM_W-1]) ? s0_b_reg.y : s0_a_reg.y;
            pz = (box && !plane_reg[i].nz[fcull_pkg::NORM_W-1]) ? s0_b_reg.z : s0_a_reg.z;
            s1_np_next[i][0] = fcull_pkg::mul_nc(plane_reg[i].nx, px);
            s1_np_next[i][1] = fcull_pkg::mul_nc(plane_reg[i].ny, py);
            s1_np_next[i][2] = fcull_pkg::mul_nc(plane_reg[i].nz, pz);
            // projected box radius terms
            s1_rp_next[i][0] = fcull_pkg::mul_abs_nc(plane_reg[i].nx, s0_b_reg.x);
            s1_rp_next[i][1] = fcull_pkg::mul_abs_nc(plane_reg[i].ny, s0_b_reg.y);
            s1_rp_next[i][2] = fcull_pkg::mul_abs_nc(plane_reg[i].nz, s0_b_reg.z);
        end
    end

    always_ff @(posedge clk)
    begin
        s1_mode_reg <= s0_mode_reg;
        s1_rad_reg  <= s0_b_reg.x;
        s1_np_reg   <= s1_np_next;
        s1_rp_reg   <= s1_rp_next;
    end

    // stage 2: signed distance and radius in q.12 of the coordinate unit
    always_comb
    begin
        for (int i = 0; i < NP; i++)
        begin
            s2_dist_next[i] = fcull_pkg::sum_t'(s1_np_reg[i][0])
                            + fcull_pkg::sum_t'(s1_np_reg[i][1])
                            + fcull_pkg::sum_t'(s1_np_reg[i][2])
                            - (fcull_pkg::sum_t'(plane_reg[i].offset) <<< fcull_pkg::FRAC_SHIFT);
            case (s1_mode_reg)
                fcull_pkg::MODE_SPHERE:
                begin
                    s2_rad_next[i] = fcull_pkg::sum_t'(s1_rad_reg) <<< fcull_pkg::FRAC_SHIFT;
                end
                fcull_pkg::MODE_BOX_EXT:
                begin
                    s2_rad_next[i] = fcull_pkg::sum_t'(s1_rp_reg[i][0])
                                   + fcull_pkg::sum_t'(s1_rp_reg[i][1])
                                   + fcull_pkg::sum_t'(s1_rp_reg[i][2]);
                end
                default:
                begin
                    s2_rad_next[i] = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        s2_dist_reg <= s2_dist_next;
        s2_rad_reg  <= s2_rad_next;
    end

    // stage 3: a plane culls when distance plus radius is negative
    always_comb
    begin
        logic signed [fcull_pkg::TEST_W-1:0] test;
        visible_next = 1'b1;
        for (int i = 0; i < NP; i++)
        begin
            test = fcull_pkg::TEST_W'(s2_dist_reg[i]) + fcull_pkg::TEST_W'(s2_rad_reg[i]);
            if (test[fcull_pkg::TEST_W-1])
            begin
                visible_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        visible_reg <= visible_next;
    end

    assign done    = done_reg;
    assign visible = visible_reg;

    // every result beat traces back to a query in the capture stage
    a_done_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(s0_vld_reg, 3))
        else $error("result beat without a matching query");

    // every captured query produces a result beat
    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        s1_vld_reg |=> ##1 done)
        else $error("query dropped in pipeline");

    // point and min/max box queries carry no radius
    a_zero_radius: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_vld_reg && (s1_mode_reg == fcull_pkg::MODE_POINT ||
                        s1_mode_reg == fcull_pkg::MODE_BOX_MINMAX))
        |=> (s2_rad_reg[0] == '0))
        else $error("nonzero radius for a radius-free mode");

endmodule
